>>> hdl/itmr_pkg.sv
// ----------------------------------------------------------------------------
// itmr_pkg
// Types and constants for the two-stage inactivity timer: event and action
// codes, register indexes and the packed payload structs.
// ----------------------------------------------------------------------------
`default_nettype none

package itmr_pkg;

    // Event codes carried in req_type.
    localparam logic [1:0] REQ_TICK     = 2'd0;
    localparam logic [1:0] REQ_ACTIVITY = 2'd1;
    localparam logic [1:0] REQ_UI       = 2'd2;

    // Action codes reported in a result.
    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_DIM      = 2'd1;
    localparam logic [1:0] ACT_REBOOT   = 2'd2;
    localparam logic [1:0] ACT_POWEROFF = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_OVERRIDE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WARNING        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNATTENDED     = 3'd4;

    localparam int unsigned CFG_DATA_W = 16;

    // A timeout of all ones disables the corresponding stage.
    localparam logic [15:0] NEVER_SECS = 16'hFFFF;

    localparam logic [15:0] RST_IDLE_TIMEOUT   = 16'd600;
    localparam logic [15:0] RST_SCREEN_TIMEOUT = 16'd60;
    localparam logic [15:0] RST_MIN_OVERRIDE   = 16'd0;
    localparam logic [7:0]  RST_WARNING        = 8'd10;

    typedef struct packed {
        logic [1:0] req_type;
        logic       usb_powered;
        logic       wallet_loaded;
    } t_in_item;

    typedef struct packed {
        logic [1:0] action;
        logic       screen_dark;
        logic       screen_woken;
        logic       warning_active;
        logic       idle_flag;
    } t_out_item;

    typedef struct packed {
        logic [15:0] idle_timeout_secs;
        logic [15:0] dark_timeout_secs;
        logic [15:0] min_override_secs;
        logic [7:0]  warning_secs;
        logic        unattended_mode;
    } t_cfg;

endpackage

`default_nettype wire

>>> hdl/itmr_cfg.sv
// ----------------------------------------------------------------------------
// itmr_cfg
// Configuration register file. Writes are registered; indexes past the
// last register are accepted and ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module itmr_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_wr_en,
    input  wire logic [itmr_pkg::CFG_IDX_W-1:0]    i_wr_index,
    input  wire logic [itmr_pkg::CFG_DATA_W-1:0]   i_wr_data,
    output itmr_pkg::t_cfg                         o_cfg
);
    import itmr_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_timeout_secs   <= RST_IDLE_TIMEOUT;
            r_cfg.dark_timeout_secs   <= RST_SCREEN_TIMEOUT;
            r_cfg.min_override_secs   <= RST_MIN_OVERRIDE;
            r_cfg.warning_secs        <= RST_WARNING;
            r_cfg.unattended_mode     <= 1'b0;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_IDLE_TIMEOUT:   r_cfg.idle_timeout_secs   <= i_wr_data;
                CFG_SCREEN_TIMEOUT: r_cfg.dark_timeout_secs   <= i_wr_data;
                CFG_MIN_OVERRIDE:   r_cfg.min_override_secs   <= i_wr_data;
                CFG_WARNING:        r_cfg.warning_secs        <= i_wr_data[7:0];
                CFG_UNATTENDED:     r_cfg.unattended_mode     <= i_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> hdl/itmr_core.sv
// ----------------------------------------------------------------------------
// itmr_core
// Timer state and its update logic. The result of an event is formed
// combinationally from the current state and the event; the state registers
// take their next values when the event is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module itmr_core #(
    parameter int unsigned TIME_WIDTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire itmr_pkg::t_cfg      i_cfg,
    input  wire logic                i_fire,
    input  wire itmr_pkg::t_in_item  i_item,
    output itmr_pkg::t_out_item      o_res
);
    import itmr_pkg::*;

    // Compare width covers both the counters and the 16-bit timeouts.
    localparam int unsigned CMP_W = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;

    logic [TIME_WIDTH-1:0] r_idle_elapsed, n_idle_elapsed;
    logic [TIME_WIDTH-1:0] r_ui_elapsed,   n_ui_elapsed;
    logic                  r_dark,         n_dark;
    logic                  r_idle,         n_idle;
    logic                  r_warn_on,      n_warn_on;
    logic [7:0]            r_warn_count,   n_warn_count;
    logic                  r_warn_poweroff, n_warn_poweroff;

    logic [TIME_WIDTH-1:0] idle_inc, ui_inc;
    logic [15:0]           idle_limit, screen_limit;
    logic                  idle_expired, screen_expired;
    logic [7:0]            count_dec;
    logic [1:0]            action;
    logic                  woken;
    logic                  skip_screen;

    assign idle_inc = (&r_idle_elapsed) ? r_idle_elapsed : r_idle_elapsed + 1'b1;
    assign ui_inc   = (&r_ui_elapsed)   ? r_ui_elapsed   : r_ui_elapsed + 1'b1;

    assign idle_limit = (i_cfg.idle_timeout_secs < i_cfg.min_override_secs)
                      ? i_cfg.min_override_secs : i_cfg.idle_timeout_secs;
    assign screen_limit = (i_cfg.dark_timeout_secs < i_cfg.min_override_secs)
                        ? i_cfg.min_override_secs : i_cfg.dark_timeout_secs;

    assign idle_expired = (idle_limit != NEVER_SECS)
                       && (CMP_W'(idle_inc) >= CMP_W'(idle_limit));
    // The disable check looks at the raw screen setting, not the limit.
    assign screen_expired = (i_cfg.dark_timeout_secs != NEVER_SECS)
                         && (CMP_W'(ui_inc) >= CMP_W'(screen_limit));

    assign count_dec = (r_warn_count != 8'd0) ? r_warn_count - 8'd1 : 8'd0;

    always_comb begin
        n_idle_elapsed  = r_idle_elapsed;
        n_ui_elapsed    = r_ui_elapsed;
        n_dark          = r_dark;
        n_idle          = r_idle;
        n_warn_on       = r_warn_on;
        n_warn_count    = r_warn_count;
        n_warn_poweroff = r_warn_poweroff;
        action          = ACT_NONE;
        woken           = 1'b0;
        skip_screen     = 1'b0;

        case (i_item.req_type) inside
            REQ_ACTIVITY, REQ_UI: begin
                n_idle         = 1'b0;
                n_idle_elapsed = '0;
                n_warn_on      = 1'b0;
                n_warn_count   = 8'd0;
                if (i_item.req_type == REQ_UI) begin
                    n_ui_elapsed = '0;
                    if (r_dark) begin
                        n_dark = 1'b0;
                        woken  = 1'b1;
                    end
                end
            end
            REQ_TICK: begin
                n_idle_elapsed = idle_inc;
                n_ui_elapsed   = ui_inc;
                if (r_warn_on) begin
                    skip_screen  = 1'b1;
                    n_warn_count = count_dec;
                    if (count_dec == 8'd0) begin
                        n_warn_on = 1'b0;
                        n_idle    = 1'b1;
                        if (i_cfg.unattended_mode) begin
                            n_dark = 1'b1;
                            action = r_dark ? ACT_NONE : ACT_DIM;
                        end else begin
                            // Reboot or power-off: the unit comes back dark and idle.
                            n_dark         = 1'b1;
                            n_idle_elapsed = '0;
                            n_ui_elapsed   = '0;
                            action = r_warn_poweroff ? ACT_POWEROFF : ACT_REBOOT;
                        end
                    end
                end else if (idle_expired) begin
                    if (i_item.usb_powered && !i_item.wallet_loaded) begin
                        n_idle = 1'b1;
                        n_dark = 1'b1;
                        action = r_dark ? ACT_NONE : ACT_DIM;
                    end else begin
                        n_warn_poweroff = !i_item.usb_powered;
                        n_warn_on       = 1'b1;
                        n_warn_count    = (i_cfg.warning_secs != 8'd0)
                                        ? i_cfg.warning_secs : 8'd1;
                        skip_screen     = 1'b1;
                    end
                end
                if (!skip_screen && screen_expired) begin
                    n_dark = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_elapsed  <= '0;
            r_ui_elapsed    <= '0;
            r_dark          <= 1'b0;
            r_idle          <= 1'b0;
            r_warn_on       <= 1'b0;
            r_warn_count    <= 8'd0;
            r_warn_poweroff <= 1'b0;
        end else if (i_fire) begin
            r_idle_elapsed  <= n_idle_elapsed;
            r_ui_elapsed    <= n_ui_elapsed;
            r_dark          <= n_dark;
            r_idle          <= n_idle;
            r_warn_on       <= n_warn_on;
            r_warn_count    <= n_warn_count;
            r_warn_poweroff <= n_warn_poweroff;
        end
    end

    assign o_res.action         = action;
    assign o_res.screen_dark    = n_dark;
    assign o_res.screen_woken   = woken;
    assign o_res.warning_active = n_warn_on;
    assign o_res.idle_flag      = n_idle;

endmodule

`default_nettype wire

>>> hdl/two_stage_inactivity_timer_core.sv
// ----------------------------------------------------------------------------
// two_stage_inactivity_timer_core
// Inactivity timer with screen dimming and a cancelable reboot or power-off
// warning. One result per event, held in an output register.
//
//   Channel   Direction  Handshake                     Payload
//   in        input      i_in_valid / o_in_ready       i_in_data (t_in_item)
//   out       output     o_out_valid / i_out_ready     o_out_data (t_out_item)
//   cfg       input      i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// One event per cycle while the output is not stalled: the state update and
// the result come out of one level of compare and counter logic behind the
// state registers, and the result is registered, so o_out_valid rises in the
// cycle after the accept. The input is ready whenever the output register is
// empty or being drained. Synchronous active-low reset restores the register
// defaults and clears all timer state; configuration writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module two_stage_inactivity_timer_core #(
    parameter int unsigned TIME_WIDTH = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output      logic                            o_in_ready,
    input  wire itmr_pkg::t_in_item              i_in_data,
    output      logic                            o_out_valid,
    input  wire logic                            i_out_ready,
    output itmr_pkg::t_out_item                  o_out_data,
    input  wire logic                            i_cfg_valid,
    output      logic                            o_cfg_ready,
    input  wire logic [itmr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [itmr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import itmr_pkg::*;

    t_cfg      cfg;
    t_out_item res;
    t_out_item r_out;
    logic      r_out_valid;
    logic      in_fire;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;

    itmr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    itmr_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_fire  (in_fire),
        .i_item  (i_in_data),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> bench/itmr_timer_check.sv
// ----------------------------------------------------------------------------
// itmr_timer_check
// Watches the event, result and configuration channels of the inactivity
// timer, keeps its own copy of the timer state and registers, predicts one
// result per accepted event and compares results in order, field by field.
// ----------------------------------------------------------------------------
module itmr_timer_check
    import itmr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  t_in_item                   i_in_data,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  t_out_item                  i_out_data,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TW = 16;

    t_cfg          regs;
    logic [TW-1:0] idle_secs;
    logic [TW-1:0] ui_secs;
    logic          screen_off;
    logic          idle_hit;
    logic          warn_run;
    logic          warn_poweroff;
    logic [7:0]    warn_left;

    t_out_item     timer_results_q[$];
    t_out_item     predicted;
    t_out_item     oldest;
    int            fails = 0;
    int            n_results = 0;

    task automatic report_mismatch(input string msg);
        if (fails < 50) $display("mismatch at %0t: %s", $realtime, msg);
        fails++;
    endtask

    task automatic check_field(input string name, input logic [1:0] got,
                               input logic [1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s is %0d, predicted %0d",
                                      n_results, name, got, want));
    endtask

    function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // The dim action only counts when it actually turns the screen dark.
    function automatic logic [1:0] dim_screen();
        idle_hit = 1'b1;
        if (!screen_off) begin
            screen_off = 1'b1;
            return ACT_DIM;
        end
        return ACT_NONE;
    endfunction

    task automatic predict_timer(input t_in_item ev, output t_out_item res);
        logic [1:0]  act;
        logic        woke;
        logic        hold_screen;
        logic [15:0] idle_lim;
        logic [15:0] scr_lim;
        act = ACT_NONE;
        woke = 1'b0;
        hold_screen = 1'b0;
        idle_lim = (regs.idle_timeout_secs < regs.min_override_secs) ?
                   regs.min_override_secs : regs.idle_timeout_secs;
        scr_lim = (regs.dark_timeout_secs < regs.min_override_secs) ?
                  regs.min_override_secs : regs.dark_timeout_secs;
        case (ev.req_type)
            REQ_ACTIVITY, REQ_UI: begin
                idle_hit = 1'b0;
                idle_secs = '0;
                warn_run = 1'b0;
                warn_left = '0;
                if (ev.req_type == REQ_UI) begin
                    ui_secs = '0;
                    if (screen_off) begin
                        screen_off = 1'b0;
                        woke = 1'b1;
                    end
                end
            end
            REQ_TICK: begin
                idle_secs = sat_inc(idle_secs);
                ui_secs = sat_inc(ui_secs);
                if (warn_run) begin
                    hold_screen = 1'b1;
                    if (warn_left != 8'd0) warn_left = warn_left - 8'd1;
                    if (warn_left == 8'd0) begin
                        warn_run = 1'b0;
                        if (regs.unattended_mode) begin
                            act = dim_screen();
                        end else begin
                            // The unit comes back dark and flagged idle.
                            idle_hit = 1'b1;
                            screen_off = 1'b1;
                            idle_secs = '0;
                            ui_secs = '0;
                            act = warn_poweroff ? ACT_POWEROFF : ACT_REBOOT;
                        end
                    end
                end else if (idle_lim != NEVER_SECS && idle_secs >= idle_lim) begin
                    if (ev.usb_powered && !ev.wallet_loaded) begin
                        act = dim_screen();
                    end else begin
                        warn_poweroff = !ev.usb_powered;
                        warn_run = 1'b1;
                        warn_left = (regs.warning_secs != 8'd0) ? regs.warning_secs : 8'd1;
                        hold_screen = 1'b1;
                    end
                end
                // The never value is taken from the raw screen setting.
                if (!hold_screen && !screen_off && regs.dark_timeout_secs != NEVER_SECS
                    && ui_secs >= scr_lim)
                    screen_off = 1'b1;
            end
            default: begin
            end
        endcase
        res.action = act;
        res.screen_dark = screen_off;
        res.screen_woken = woke;
        res.warning_active = warn_run;
        res.idle_flag = idle_hit;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.idle_timeout_secs <= RST_IDLE_TIMEOUT;
            regs.dark_timeout_secs <= RST_SCREEN_TIMEOUT;
            regs.min_override_secs <= RST_MIN_OVERRIDE;
            regs.warning_secs <= RST_WARNING;
            regs.unattended_mode <= 1'b0;
            idle_secs = '0;
            ui_secs = '0;
            screen_off = 1'b0;
            idle_hit = 1'b0;
            warn_run = 1'b0;
            warn_poweroff = 1'b0;
            warn_left = '0;
            timer_results_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (timer_results_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none predicted",
                                              n_results));
                end else begin
                    oldest = timer_results_q.pop_front();
                    check_field("action", i_out_data.action, oldest.action);
                    check_field("screen_dark", {1'b0, i_out_data.screen_dark},
                                {1'b0, oldest.screen_dark});
                    check_field("screen_woken", {1'b0, i_out_data.screen_woken},
                                {1'b0, oldest.screen_woken});
                    check_field("warning_active", {1'b0, i_out_data.warning_active},
                                {1'b0, oldest.warning_active});
                    check_field("idle_flag", {1'b0, i_out_data.idle_flag},
                                {1'b0, oldest.idle_flag});
                end
                n_results++;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IDLE_TIMEOUT:   regs.idle_timeout_secs <= i_cfg_data;
                    CFG_SCREEN_TIMEOUT: regs.dark_timeout_secs <= i_cfg_data;
                    CFG_MIN_OVERRIDE:   regs.min_override_secs <= i_cfg_data;
                    CFG_WARNING:        regs.warning_secs <= i_cfg_data[7:0];
                    CFG_UNATTENDED:     regs.unattended_mode <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_timer(i_in_data, predicted);
                timer_results_q.push_back(predicted);
            end
        end
        o_pending <= timer_results_q.size();
        o_fail_count <= fails;
    end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the two-stage inactivity timer: directed event sequences for
// dimming, warnings, reboot, power-off and cancelation, then random phases
// under changing register settings with random stalls on both sides, and a
// closing tick run with both timeouts off, then the idle timeout near maximum.
// ----------------------------------------------------------------------------
module tb
    import itmr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         LONG_HOLD   = 250;
    localparam int         STALL_LIMIT = 3000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int                    fail_count;
    int                    pending;
    int                    quiet_cycles = 0;
    logic                  no_idle = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    two_stage_inactivity_timer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    itmr_timer_check timer_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic t_in_item make_event(input logic [1:0] req, input logic usb,
                                            input logic wallet);
        t_in_item ev;
        ev.req_type = req;
        ev.usb_powered = usb;
        ev.wallet_loaded = wallet;
        return ev;
    endfunction

    // Mostly ticks, so that the timeouts are actually reached between activity.
    function automatic t_in_item rand_event(input logic usb, input logic wallet);
        int         r;
        logic [1:0] req;
        r = $urandom_range(0, 99);
        if (r < 80) req = REQ_TICK;
        else if (r < 87) req = REQ_ACTIVITY;
        else if (r < 96) req = REQ_UI;
        else req = REQ_UNUSED;
        return make_event(req, ($urandom_range(0, 9) == 0) ? !usb : usb,
                          ($urandom_range(0, 9) == 0) ? !wallet : wallet);
    endfunction

    function automatic t_cfg pick_config(input int phase);
        t_cfg c;
        if (phase == 0) begin
            c.idle_timeout_secs = NEVER_SECS;
            c.dark_timeout_secs = NEVER_SECS;
            c.min_override_secs = NEVER_SECS;
            c.warning_secs = 8'hFF;
            c.unattended_mode = 1'b1;
        end else if (phase == 1) begin
            c = '0;
        end else begin
            c.idle_timeout_secs = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                                  16'($urandom_range(0, 5));
            c.dark_timeout_secs = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                                  16'($urandom_range(0, 7));
            c.min_override_secs = ($urandom_range(0, 3) == 0) ?
                                  16'($urandom_range(0, 6)) : 16'd0;
            c.warning_secs = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                             8'($urandom_range(0, 3));
            c.unattended_mode = 1'($urandom_range(0, 1));
        end
        return c;
    endfunction

    // Leaves the write valid high so that back-to-back writes need no toggle.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (!(cfg_valid && cfg_ready));
    endtask

    task automatic write_config(input t_cfg c);
        cfg_write(CFG_IDLE_TIMEOUT, c.idle_timeout_secs);
        cfg_write(CFG_SCREEN_TIMEOUT, c.dark_timeout_secs);
        cfg_write(CFG_MIN_OVERRIDE, c.min_override_secs);
        cfg_write(CFG_WARNING, {8'($urandom), c.warning_secs});
        cfg_write(CFG_UNATTENDED, {15'($urandom), c.unattended_mode});
        // Writes to the unused indexes must leave every register alone.
        if ($urandom_range(0, 2) == 0)
            cfg_write(CFG_UNATTENDED + 3'($urandom_range(1, 3)), 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_event(input t_in_item ev);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= ev;
        do @(posedge i_clk); while (!(in_valid && in_ready));
    endtask

    // Waits until every predicted result has been taken and the block is quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            // One long hold-off fills the output register and stalls the input.
            if (taken == 300) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 9);
            if (gap != 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!(out_valid && out_ready));
            taken++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_cfg c;
        logic usb;
        logic wallet;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Dim, repeated dim, wake, reboot, canceled and completed power-off,
        // all with a zero warning length that counts as one second.
        c.idle_timeout_secs = 16'd2;
        c.dark_timeout_secs = 16'd4;
        c.min_override_secs = 16'd0;
        c.warning_secs = 8'd0;
        c.unattended_mode = 1'b0;
        write_config(c);
        send_event(make_event(REQ_UI, 1'b1, 1'b0));
        send_event(make_event(REQ_TICK, 1'b1, 1'b0));
        send_event(make_event(REQ_TICK, 1'b1, 1'b0));
        send_event(make_event(REQ_TICK, 1'b1, 1'b0));
        send_event(make_event(REQ_UI, 1'b1, 1'b0));
        send_event(make_event(REQ_TICK, 1'b1, 1'b1));
        send_event(make_event(REQ_TICK, 1'b1, 1'b1));
        send_event(make_event(REQ_TICK, 1'b1, 1'b1));
        send_event(make_event(REQ_TICK, 1'b0, 1'b0));
        send_event(make_event(REQ_TICK, 1'b0, 1'b0));
        send_event(make_event(REQ_ACTIVITY, 1'b0, 1'b1));
        send_event(make_event(REQ_TICK, 1'b0, 1'b1));
        send_event(make_event(REQ_TICK, 1'b0, 1'b1));
        send_event(make_event(REQ_TICK, 1'b0, 1'b1));
        send_event(make_event(REQ_UNUSED, 1'b1, 1'b1));
        send_event(make_event(REQ_UI, 1'b0, 1'b0));
        settle();

        // The minimum override stretches both timeouts; the unattended mode
        // turns the expired warning into dimming.
        c.idle_timeout_secs = 16'd1;
        c.dark_timeout_secs = 16'd0;
        c.min_override_secs = 16'd3;
        c.warning_secs = 8'd2;
        c.unattended_mode = 1'b1;
        write_config(c);
        repeat (5) send_event(make_event(REQ_TICK, 1'b0, 1'b0));
        send_event(make_event(REQ_UI, 1'b0, 1'b0));

        for (int ph = 0; ph < 10; ph++) begin
            settle();
            write_config(pick_config(ph));
            no_idle = (ph == 4);
            usb = 1'($urandom_range(0, 1));
            wallet = 1'($urandom_range(0, 1));
            for (int k = 0; k < 70; k++) begin
                if ($urandom_range(0, 19) == 0) begin
                    usb = 1'($urandom_range(0, 1));
                    wallet = 1'($urandom_range(0, 1));
                end
                send_event(rand_event(usb, wallet));
            end
        end

        // A back-to-back tick run with both timeouts off, then the idle
        // timeout just below the counter maximum.
        settle();
        no_idle = 1'b1;
        c.idle_timeout_secs = NEVER_SECS;
        c.dark_timeout_secs = NEVER_SECS;
        c.min_override_secs = NEVER_SECS;
        c.warning_secs = 8'd5;
        c.unattended_mode = 1'b0;
        write_config(c);
        send_event(make_event(REQ_UI, 1'b1, 1'b0));
        repeat (20) send_event(make_event(REQ_TICK, 1'b1, 1'b0));
        settle();
        c.idle_timeout_secs = NEVER_SECS - 16'd1;
        c.min_override_secs = 16'd0;
        write_config(c);
        no_idle = 1'b0;
        send_event(make_event(REQ_TICK, 1'b1, 1'b0));
        send_event(make_event(REQ_TICK, 1'b1, 1'b0));
        send_event(make_event(REQ_UI, 1'b1, 1'b0));
        settle();
        repeat (10) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
